// File: rtl/rdht_pkg.sv
`default_nettype none
package rdht_pkg;

  localparam int TABLE_BITS_DEF = 10;
  localparam int MAX_RANK_DEF   = 32;
  localparam int LIMIT_W        = 10;
  localparam int COUNT_W        = 11;
  localparam int RANK_W         = 6;
  localparam int POS_W          = 48;
  localparam int KEY_W          = 64;
  localparam int HOME_LSB       = 40;
  localparam int RANK_CEIL      = 63;
  localparam int SWEEP_LAPS     = 66;

  typedef struct packed {
    logic [KEY_W-1:0]  key_high;
    logic [KEY_W-1:0]  key_low;
    logic [POS_W-1:0]  position;
    logic [RANK_W-1:0] rank;
  } in_t;

  typedef struct packed {
    logic              match_found;
    logic [POS_W-1:0]  match_position;
    logic [RANK_W-1:0] min_rank;
    logic [COUNT_W-1:0] entry_count;
  } out_t;

  typedef struct packed {
    logic [KEY_W-1:0] key_high;
    logic [KEY_W-1:0] key_low;
    logic [POS_W-1:0] position;
  } slot_t;

endpackage
`default_nettype wire

// File: rtl/ranked_digest_hash_table.sv
// Ranked digest hash table: linear-probing store of 128-bit digests with
// rank-driven eviction.
//
// Input: a request is taken at a rising edge with start high and busy low.
// in_data carries the digest halves, the stream position and the rank.
// Output: exactly one result per request, shown for one cycle with out_valid
// high. The receiver cannot stall; results are never held back.
// Config: cfg_valid/cfg_ready write the 10-bit occupancy limit; cfg_ready is
// always high. Write it only while busy is low.
//
// Probing: each probed slot passes through a read state and then an
// evaluate state (S_PROBE_RD, S_PROBE_EV); an eviction sweep does the
// same for each slot swept (S_SWEEP_RD, S_SWEEP_EV). Displaced entries
// restart probing at their own home bucket. busy is high for the whole
// request; the next request can enter the cycle the result is shown.
//
// Reset: a clearing pass writes all 2**TABLE_BITS rank slots (1024 by
// default) to empty, one per cycle, with busy high. Config writes are
// taken during the pass.
`default_nettype none
module ranked_digest_hash_table
  import rdht_pkg::*;
#(
  parameter int TABLE_BITS = TABLE_BITS_DEF,
  parameter int MAX_RANK   = MAX_RANK_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire in_t                in_data,
  output logic                    out_valid,
  output out_t                    out_data,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [LIMIT_W-1:0] cfg_data
);

  localparam int SIZE    = 1 << TABLE_BITS;
  localparam int CNT_W   = TABLE_BITS + 1;
  localparam int CMP_W   = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
  localparam int LIMIT_RESET = (SIZE * 2 / 3) % (1 << LIMIT_W);
  localparam int LAP_W   = 7;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_PROBE_RD, S_PROBE_EV, S_SWEEP_RD, S_SWEEP_EV
  } state_t;

  // Slot storage: rank store is cleared by the reset pass, payload is not.
  logic [RANK_W-1:0] rank_mem [SIZE];
  slot_t             data_mem [SIZE];
  logic [RANK_W-1:0] rank_q;
  slot_t             data_q;

  state_t               state_r, state_nxt;
  in_t                  cur_r, cur_nxt;
  logic [TABLE_BITS-1:0] h_r, h_nxt;
  logic [TABLE_BITS-1:0] probe_r, probe_nxt;
  logic [TABLE_BITS-1:0] sp_r, sp_nxt;
  logic [LAP_W-1:0]     lap_r, lap_nxt;
  logic                 top_r, top_nxt;
  logic                 match_r, match_nxt;
  logic [POS_W-1:0]     mpos_r, mpos_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [RANK_W-1:0]    minr_r, minr_nxt;
  logic [LIMIT_W-1:0]   limit_r, limit_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_t                 out_data_r, out_data_nxt;

  logic                  rank_we, data_we;
  logic [TABLE_BITS-1:0] rank_wa, rank_ra;
  logic [RANK_W-1:0]     rank_wd;
  logic                  done_now;
  logic                  key_eq;
  logic [CNT_W-1:0]      base_cnt;
  logic [RANK_W-1:0]     in_rank;

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign rank_ra = (state_r == S_SWEEP_RD) ? sp_r : h_r;
  assign key_eq  = (data_q.key_high == cur_r.key_high) &&
                   (data_q.key_low == cur_r.key_low);

  // Clamp the offered rank into 1..MAX_RANK.
  always_comb begin
    if (in_data.rank == '0) begin
      in_rank = RANK_W'(1);
    end else if (in_data.rank > RANK_W'(MAX_RANK)) begin
      in_rank = RANK_W'(MAX_RANK);
    end else begin
      in_rank = in_data.rank;
    end
  end

  // Count before placement; a minimum-rank overwrite frees its slot first.
  always_comb begin
    if (rank_q == minr_r && cnt_r != '0) begin
      base_cnt = cnt_r - CNT_W'(1);
    end else begin
      base_cnt = cnt_r;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cur_nxt   = cur_r;
    h_nxt     = h_r;
    probe_nxt = probe_r;
    sp_nxt    = sp_r;
    lap_nxt   = lap_r;
    top_nxt   = top_r;
    match_nxt = match_r;
    mpos_nxt  = mpos_r;
    cnt_nxt   = cnt_r;
    minr_nxt  = minr_r;
    limit_nxt = limit_r;
    rank_we   = 1'b0;
    data_we   = 1'b0;
    rank_wa   = h_r;
    rank_wd   = cur_r.rank;
    done_now  = 1'b0;

    if (cfg_valid) begin
      limit_nxt = cfg_data;
    end

    unique case (state_r)
      S_CLEAR: begin
        // Sweep the rank store to empty; the pointer wraps back to zero.
        rank_we = 1'b1;
        rank_wa = sp_r;
        rank_wd = '0;
        sp_nxt  = sp_r + TABLE_BITS'(1);
        if (&sp_r) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cur_nxt      = in_data;
          cur_nxt.rank = in_rank;
          h_nxt        = in_data.key_high[HOME_LSB +: TABLE_BITS];
          probe_nxt    = '0;
          top_nxt      = 1'b1;
          match_nxt    = 1'b0;
          mpos_nxt     = '0;
          state_nxt    = S_PROBE_RD;
        end
      end
      S_PROBE_RD: begin
        state_nxt = S_PROBE_EV;
      end
      S_PROBE_EV: begin
        if (rank_q == '0 || (!key_eq && rank_q == minr_r)) begin
          // Place the carried entry here.
          rank_we = 1'b1;
          data_we = 1'b1;
          cnt_nxt = base_cnt + CNT_W'(1);
          if (CMP_W'(cnt_nxt) > CMP_W'(limit_r)) begin
            lap_nxt   = '0;
            state_nxt = S_SWEEP_RD;
          end else begin
            done_now = 1'b1;
          end
        end else if (key_eq) begin
          // Report only for the offered digest; drop a displaced duplicate.
          if (top_r) begin
            match_nxt = 1'b1;
            mpos_nxt  = data_q.position;
          end
          done_now = 1'b1;
        end else if (rank_q < cur_r.rank) begin
          // Displace the lower-ranked occupant and reinsert it.
          rank_we           = 1'b1;
          data_we           = 1'b1;
          cur_nxt.key_high  = data_q.key_high;
          cur_nxt.key_low   = data_q.key_low;
          cur_nxt.position  = data_q.position;
          cur_nxt.rank      = rank_q;
          h_nxt             = data_q.key_high[HOME_LSB +: TABLE_BITS];
          probe_nxt         = '0;
          top_nxt           = 1'b0;
          state_nxt         = S_PROBE_RD;
        end else begin
          // Advance; drop the carried entry after a full lap.
          h_nxt     = h_r + TABLE_BITS'(1);
          probe_nxt = probe_r + TABLE_BITS'(1);
          if (&probe_r) begin
            done_now = 1'b1;
          end else begin
            state_nxt = S_PROBE_RD;
          end
        end
      end
      S_SWEEP_RD: begin
        state_nxt = S_SWEEP_EV;
      end
      S_SWEEP_EV: begin
        if (rank_q != '0 && rank_q <= minr_r) begin
          // Evict here and leave the pointer on this slot.
          rank_we = 1'b1;
          rank_wa = sp_r;
          rank_wd = '0;
          if (cnt_r != '0) begin
            cnt_nxt = cnt_r - CNT_W'(1);
          end
          done_now = 1'b1;
        end else if (&sp_r) begin
          // Wrap: raise the minimum rank, give up after the last lap.
          if (minr_r < RANK_W'(RANK_CEIL)) begin
            minr_nxt = minr_r + RANK_W'(1);
          end
          sp_nxt  = '0;
          lap_nxt = lap_r + LAP_W'(1);
          if (lap_r == LAP_W'(SWEEP_LAPS - 1)) begin
            done_now = 1'b1;
          end else begin
            state_nxt = S_SWEEP_RD;
          end
        end else begin
          sp_nxt    = sp_r + TABLE_BITS'(1);
          state_nxt = S_SWEEP_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (done_now) begin
      state_nxt = S_IDLE;
    end
    out_valid_nxt               = done_now;
    out_data_nxt.match_found    = match_nxt;
    out_data_nxt.match_position = mpos_nxt;
    out_data_nxt.min_rank       = minr_nxt;
    out_data_nxt.entry_count    = COUNT_W'(cnt_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      sp_r        <= '0;
      lap_r       <= '0;
      top_r       <= 1'b0;
      match_r     <= 1'b0;
      mpos_r      <= '0;
      cnt_r       <= '0;
      minr_r      <= RANK_W'(1);
      limit_r     <= LIMIT_W'(LIMIT_RESET);
      out_valid_r <= 1'b0;
      probe_r     <= '0;
      h_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      sp_r        <= sp_nxt;
      lap_r       <= lap_nxt;
      top_r       <= top_nxt;
      match_r     <= match_nxt;
      mpos_r      <= mpos_nxt;
      cnt_r       <= cnt_nxt;
      minr_r      <= minr_nxt;
      limit_r     <= limit_nxt;
      out_valid_r <= out_valid_nxt;
      probe_r     <= probe_nxt;
      h_r         <= h_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (rank_we) begin
      rank_mem[rank_wa] <= rank_wd;
    end
    rank_q <= rank_mem[rank_ra];
  end

  always_ff @(posedge clk) begin
    if (data_we) begin
      data_mem[h_r] <= slot_t'{cur_r.key_high, cur_r.key_low, cur_r.position};
    end
    data_q <= data_mem[h_r];
  end

endmodule
`default_nettype wire

// File: rtl/rdht_checker.sv
`default_nettype none
module rdht_checker
  import rdht_pkg::*;
(
  input wire logic clk,
  input wire logic rst_n,
  input wire logic start,
  input wire logic busy,
  input wire logic out_valid,
  input wire out_t out_data
);

  // Reset always starts the clearing pass.
  a_reset_clear: assert property (@(posedge clk) !rst_n |=> busy)
    else $error("busy low after reset");

  // An accepted request occupies the block.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("request accepted but block not busy");

  // A result is shown as the block goes free.
  a_result_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while busy");

  a_result_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_min_rank: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.min_rank != '0))
    else $error("minimum rank reported as zero");

endmodule

bind ranked_digest_hash_table rdht_checker u_rdht_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);
`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import rdht_pkg::*;

  localparam int SLOTS = 1 << TABLE_BITS_DEF;

  // Reference behavior of the digest table, kept in step with every accepted
  // request, plus the queue of results that those requests must produce.
  class digest_table_board;
    bit [RANK_W-1:0]  slot_rk  [SLOTS];
    bit [KEY_W-1:0]   slot_kh  [SLOTS];
    bit [KEY_W-1:0]   slot_kl  [SLOTS];
    bit [POS_W-1:0]   slot_pos [SLOTS];
    int unsigned      live_count;
    int unsigned      sweep_at;
    int unsigned      floor_rank;
    int unsigned      limit;
    out_t             due_results[$];
    int               errors;

    function new();
      foreach (slot_rk[i]) slot_rk[i] = '0;
      live_count = 0;
      sweep_at   = 0;
      floor_rank = 1;
      limit      = (SLOTS * 2) / 3;
      errors     = 0;
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endtask

    function void set_limit(bit [LIMIT_W-1:0] v);
      limit = 32'(v);
    endfunction

    // Remove one entry at or below the floor rank, resuming where the last
    // sweep stopped; each lap that finds nothing raises the floor.
    function void evict_one();
      for (int lap = 0; lap < SWEEP_LAPS; lap++) begin
        while (sweep_at < SLOTS) begin
          if (slot_rk[sweep_at] != 0 && slot_rk[sweep_at] <= floor_rank) begin
            slot_rk[sweep_at] = '0;
            if (live_count > 0) live_count--;
            return;
          end
          sweep_at++;
        end
        if (floor_rank < RANK_CEIL) floor_rank++;
        sweep_at = 0;
      end
    endfunction

    function out_t insert_digest(in_t req);
      bit [KEY_W-1:0]  ch, cl, tk;
      bit [POS_W-1:0]  cp, tp;
      int unsigned     cr, r, h, probes;
      bit              first, displaced, done;
      out_t            res;
      ch = req.key_high;
      cl = req.key_low;
      cp = req.position;
      cr = 32'(req.rank);
      first = 1;
      res = '0;
      if (cr == 0) cr = 1;
      if (cr > MAX_RANK_DEF) cr = MAX_RANK_DEF;
      // displaced entries always carry a lower rank, so this terminates
      for (int rounds = 0; rounds < 70; rounds++) begin
        h = 32'(ch[HOME_LSB +: TABLE_BITS_DEF]);
        displaced = 0;
        done = 0;
        for (probes = 0; probes < SLOTS; probes++) begin
          r = 32'(slot_rk[h]);
          if (r == 0) break;
          if (slot_kh[h] == ch && slot_kl[h] == cl) begin
            if (first) begin
              res.match_found = 1'b1;
              res.match_position = slot_pos[h];
            end
            done = 1;
            break;
          end
          if (r == floor_rank) begin
            if (live_count > 0) live_count--;
            break;
          end
          if (r < cr) begin
            tk = slot_kh[h]; slot_kh[h] = ch; ch = tk;
            tk = slot_kl[h]; slot_kl[h] = cl; cl = tk;
            tp = slot_pos[h]; slot_pos[h] = cp; cp = tp;
            slot_rk[h] = RANK_W'(cr);
            cr = r;
            first = 0;
            displaced = 1;
            break;
          end
          h = (h + 1) % SLOTS;
        end
        if (done) break;
        if (displaced) continue;
        if (probes >= SLOTS) break;
        slot_kh[h] = ch;
        slot_kl[h] = cl;
        slot_pos[h] = cp;
        slot_rk[h] = RANK_W'(cr);
        live_count++;
        if (live_count > limit) evict_one();
        break;
      end
      res.min_rank = RANK_W'(floor_rank);
      res.entry_count = COUNT_W'(live_count);
      return res;
    endfunction

    function void note_request(in_t req);
      due_results.push_back(insert_digest(req));
    endfunction

    task check_result(out_t got);
      out_t want;
      if (due_results.size() == 0) begin
        report("result with no request outstanding");
        return;
      end
      want = due_results.pop_front();
      if (got.match_found !== want.match_found)
        report($sformatf("match_found %0b, want %0b", got.match_found, want.match_found));
      if (got.match_position !== want.match_position)
        report($sformatf("match_position %h, want %h",
                         got.match_position, want.match_position));
      if (got.min_rank !== want.min_rank)
        report($sformatf("min_rank %0d, want %0d", got.min_rank, want.min_rank));
      if (got.entry_count !== want.entry_count)
        report($sformatf("entry_count %0d, want %0d", got.entry_count, want.entry_count));
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  in_t                in_data = '0;
  logic               out_valid;
  out_t               out_data;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [LIMIT_W-1:0] cfg_data = '0;

  digest_table_board board = new();
  bit [KEY_W-1:0]     seen_kh[$];
  bit [KEY_W-1:0]     seen_kl[$];
  bit                 no_idle;

  ranked_digest_hash_table u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Results cannot be held off: check every strobed result at the edge
  // that ends its cycle.
  always @(posedge clk) begin
    if (rst_n && out_valid) board.check_result(out_data);
  end

  // Present a request after a random gap; keep start high across
  // back-to-back requests instead of dropping it.
  task send_request(in_t req);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (busy);
    board.note_request(req);
    seen_kh.push_back(req.key_high);
    seen_kl.push_back(req.key_low);
    if (seen_kh.size() > 64) begin
      void'(seen_kh.pop_front());
      void'(seen_kl.pop_front());
    end
  endtask

  // Hold the sender until every outstanding result is back and the block
  // has gone idle.
  task drain();
    @(posedge clk);
    start <= 1'b0;
    while (board.due_results.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task write_limit(bit [LIMIT_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    board.set_limit(v);
  endtask

  function automatic in_t make_request(int home_span);
    in_t req;
    req.key_high = {$urandom, $urandom};
    req.key_low  = {$urandom, $urandom};
    // crowd homes into a narrow window to force long chains and displacement
    if (home_span > 0)
      req.key_high[HOME_LSB +: TABLE_BITS_DEF] =
        TABLE_BITS_DEF'($urandom_range(0, home_span - 1));
    // reuse a recent digest so that matches happen
    if (seen_kh.size() > 0 && $urandom_range(0, 99) < 25) begin
      int k;
      k = $urandom_range(0, seen_kh.size() - 1);
      req.key_high = seen_kh[k];
      req.key_low  = seen_kl[k];
    end
    req.position = POS_W'({$urandom, $urandom});
    case ($urandom_range(0, 19))
      0:       req.rank = '0;
      1:       req.rank = RANK_W'($urandom_range(MAX_RANK_DEF + 1, 63));
      default: req.rank = RANK_W'($urandom_range(1, MAX_RANK_DEF));
    endcase
    return req;
  endfunction

  task directed_requests();
    in_t req;
    // all-zero and all-one digests, fields at their extremes
    req = '{key_high: '0, key_low: '0, position: '0, rank: 6'd1};
    send_request(req);
    req = '{key_high: '1, key_low: '1, position: '1, rank: 6'd32};
    send_request(req);
    // same digest again: match with stored position
    req = '{key_high: '0, key_low: '0, position: 48'h123, rank: 6'd5};
    send_request(req);
    req = '{key_high: '1, key_low: '1, position: '0, rank: 6'd1};
    send_request(req);
    // rank zero and ranks above the ceiling
    req = '{key_high: 64'h00AA_0000_0000_0001, key_low: 64'h1, position: 48'h7, rank: 6'd0};
    send_request(req);
    req = '{key_high: 64'h00AA_0000_0000_0002, key_low: 64'h2, position: 48'h8, rank: 6'd63};
    send_request(req);
    req = '{key_high: 64'h00AA_0000_0000_0003, key_low: 64'h3, position: 48'h9, rank: 6'd33};
    send_request(req);
    // same home, rising rank: displacement and reinsertion
    for (int i = 0; i < 6; i++) begin
      req.key_high = {8'h5A, 16'h0007, 40'(i)};
      req.key_low = 64'(i * 3 + 1);
      req.position = 48'(1000 + i);
      req.rank = 6'(2 + 4 * i);
      send_request(req);
    end
    // repeat one displaced digest: match after displacement
    req.key_high = {8'h5A, 16'h0007, 40'd0};
    req.key_low = 64'd1;
    req.rank = 6'd9;
    send_request(req);
    // wrap from the top bucket
    for (int i = 0; i < 3; i++) begin
      req.key_high = {8'h11, 16'h03FF, 40'(i)};
      req.key_low = '1;
      req.position = '1;
      req.rank = 6'(i + 1);
      send_request(req);
    end
  endtask

  initial begin
    bit [LIMIT_W-1:0] limits[6];
    int per_phase, span;
    limits = '{10'd1, 10'd3, 10'd682, 10'd1023, 10'd40, 10'd1};
    limits[5] = LIMIT_W'($urandom_range(1, 1023));
    no_idle = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    // tight limit first so eviction and floor-rank raising show up early
    write_limit(10'd2);
    directed_requests();
    drain();
    foreach (limits[p]) begin
      write_limit(limits[p]);
      per_phase = (p == 3) ? 260 : 130;
      for (int n = 0; n < per_phase; n++) begin
        if (n % 40 == 0) no_idle = ($urandom_range(0, 2) == 0);
        case ($urandom_range(0, 3))
          0:       span = 0;
          1:       span = 8;
          default: span = 64;
        endcase
        send_request(make_request(span));
      end
      drain();
    end
    repeat (50) @(posedge clk);
    if (board.errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  // Abort a hung run; long sweeps and probe chains make single requests slow.
  initial begin
    #1_000_000_000;
    $display("testbench: errors");
    $finish;
  end

endmodule
